// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

	localparam int DATA_W = 32;
	localparam int UP_W = 24;
	localparam int CFG_W = 48;
	localparam int IDX_W = 3;

	localparam logic [DATA_W-1:0] C_B6_OFS = 32'd4000;
	localparam logic [DATA_W-1:0] C_HALF = 32'd32768;
	localparam logic [DATA_W-1:0] C_B7_SCALE = 32'd50000;
	localparam logic [DATA_W-1:0] C_P_K1 = 32'd3038;
	localparam logic [DATA_W-1:0] C_P_K2 = 32'hFFFF_E343; // -7357
	localparam logic [DATA_W-1:0] C_P_K3 = 32'd3791;
	localparam logic signed [DATA_W-1:0] C_PRESS_MAX = 32'sd1048575;
	localparam logic signed [DATA_W-1:0] C_TEMP_MAX = 32'sd32767;
	localparam logic signed [DATA_W-1:0] C_TEMP_MIN = -32'sd32768;

	typedef enum logic [IDX_W-1:0] {
		REG_OSS = 3'd0,
		REG_CAL_A_S = 3'd1,
		REG_CAL_A_U = 3'd2,
		REG_CAL_B = 3'd3,
		REG_CAL_M = 3'd4
	} reg_idx_t;

	function automatic logic [DATA_W-1:0] sx16(input logic [15:0] v);
		return {{(DATA_W-16){v[15]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] mul_lo(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [2*DATA_W-1:0] p;
		p = a * b;
		return p[DATA_W-1:0];
	endfunction

	function automatic logic [DATA_W-1:0] asr(input logic [DATA_W-1:0] v,
			input int unsigned n);
		logic signed [DATA_W-1:0] s;
		s = $signed(v) >>> n;
		return DATA_W'(s);
	endfunction

endpackage

// ----- rtl/bpc_div_cell.sv -----
module bpc_div_cell import bpc_pkg::*; #(
	parameter int W = DATA_W,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [W-1:0]    rem_in,
	input  logic [W-1:0]    dd_in,
	input  logic [W-1:0]    dvs_in,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [W-1:0]    rem_out,
	output logic [W-1:0]    dd_out,
	output logic [W-1:0]    dvs_out,
	output logic [SB_W-1:0] sb_out
);

	logic [W:0] r2, diff;
	logic ge;

	// one restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		r2 = {rem_in, dd_in[W-1]};
		diff = r2 - {1'b0, dvs_in};
		ge = r2 >= {1'b0, dvs_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[W-1:0] : r2[W-1:0];
			dd_out <= {dd_in[W-2:0], ge};
			dvs_out <= dvs_in;
			sb_out <= sb_in;
		end
	end

endmodule

// ----- rtl/bpc_div_chain.sv -----
module bpc_div_chain import bpc_pkg::*; #(
	parameter int W = DATA_W,
	parameter int SB_W = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [W-1:0]    dividend,
	input  logic [W-1:0]    divisor,
	input  logic [SB_W-1:0] sb_in,
	output logic            out_valid,
	output logic [W-1:0]    quotient,
	output logic [SB_W-1:0] sb_out
);

	logic            v_l [W+1];
	logic [W-1:0]    rem_l [W+1];
	logic [W-1:0]    dd_l [W+1];
	logic [W-1:0]    dvs_l [W+1];
	logic [SB_W-1:0] sb_l [W+1];

	assign v_l[0] = in_valid;
	assign rem_l[0] = '0;
	assign dd_l[0] = dividend;
	assign dvs_l[0] = divisor;
	assign sb_l[0] = sb_in;

	for (genvar i = 0; i < W; i++) begin : g_cell
		bpc_div_cell #(.W(W), .SB_W(SB_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v_l[i]), .rem_in(rem_l[i]), .dd_in(dd_l[i]),
			.dvs_in(dvs_l[i]), .sb_in(sb_l[i]),
			.out_valid(v_l[i+1]), .rem_out(rem_l[i+1]), .dd_out(dd_l[i+1]),
			.dvs_out(dvs_l[i+1]), .sb_out(sb_l[i+1])
		);
	end

	// quotient bits have shifted in from the bottom as the dividend left
	assign out_valid = v_l[W];
	assign quotient = dd_l[W];
	assign sb_out = sb_l[W];

endmodule

// ----- rtl/barometric_pressure_compensation.sv -----
// Barometric sensor compensation pipeline. Each item carries one raw
// temperature word and one raw 24-bit pressure readout and yields one result
// item: temperature in tenths of a degree, pressure in pascals clamped to
// 0..1048575, and a fault flag that is set (with both values 0) when either
// divisor is zero. One item is accepted per cycle when the output side keeps
// up. There are 76 register stages. The depth is set mostly by the two
// 32-cell quotient chains (one cell per quotient bit), with the multiplier
// stages between them. The whole pipeline advances together and holds
// while a result waits at the output. Load the calibration registers
// (index 0 oss, 1..4 the packed calibration words) while no item is in
// flight.
module barometric_pressure_compensation import bpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [15:0]             raw_temp,
	input  logic [23:0]             raw_press_bytes,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [15:0]      temp_tenths,
	output logic [19:0]             press_pa,
	output logic                    div_fault
);

	localparam int SB1_W = 2 + DATA_W + UP_W;
	localparam int SB2_W = 2 + DATA_W;

	// configuration
	logic [1:0]  oss_q;
	logic [47:0] cal_as_q, cal_au_q;
	logic [31:0] cal_b_q, cal_m_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q <= '0;
			cal_as_q <= '0;
			cal_au_q <= '0;
			cal_b_q <= '0;
			cal_m_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OSS: oss_q <= cfg_data[1:0];
				REG_CAL_A_S: cal_as_q <= cfg_data;
				REG_CAL_A_U: cal_au_q <= cfg_data;
				REG_CAL_B: cal_b_q <= cfg_data[31:0];
				REG_CAL_M: cal_m_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic [DATA_W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(cal_as_q[15:0]);
	assign ac2 = sx16(cal_as_q[31:16]);
	assign ac3 = sx16(cal_as_q[47:32]);
	assign ac4 = {16'b0, cal_au_q[15:0]};
	assign ac5 = {16'b0, cal_au_q[31:16]};
	assign ac6 = {16'b0, cal_au_q[47:32]};
	assign b1 = sx16(cal_b_q[15:0]);
	assign b2 = sx16(cal_b_q[31:16]);
	assign mc = sx16(cal_m_q[15:0]);
	assign md = sx16(cal_m_q[31:16]);

	// one enable for the whole pipeline: advance unless a result is stuck
	logic adv;
	logic out_valid_q;
	assign adv = !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 1: UT - AC6, raw pressure aligned to oss
	logic v_s1;
	logic [DATA_W-1:0] d_s1;
	logic [UP_W-1:0] up_s1;
	// stage 2: X1 of the temperature path
	logic v_s2;
	logic [DATA_W-1:0] x1_s2;
	logic [UP_W-1:0] up_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= {16'b0, raw_temp} - ac6;
			up_s1 <= raw_press_bytes >> (4'd8 - {2'b0, oss_q});
			x1_s2 <= asr(mul_lo(d_s1, ac5), 15);
			up_s2 <= up_s1;
		end
	end

	// signed MC<<11 / (X1+MD): divide magnitudes, fix the sign after
	logic [DATA_W-1:0] num1, den1, num1_abs, den1_abs, q1;
	logic neg1, fault1;
	logic [SB1_W-1:0] sb1_in, sb1_out;
	logic v_d1;

	always_comb begin
		num1 = {mc[DATA_W-12:0], 11'b0};
		den1 = x1_s2 + md;
		num1_abs = num1[DATA_W-1] ? -num1 : num1;
		den1_abs = den1[DATA_W-1] ? -den1 : den1;
		neg1 = num1[DATA_W-1] ^ den1[DATA_W-1];
		fault1 = den1 == '0;
		sb1_in = {neg1, fault1, x1_s2, up_s2};
	end

	bpc_div_chain #(.W(DATA_W), .SB_W(SB1_W)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s2),
		.dividend(num1_abs), .divisor(den1_abs), .sb_in(sb1_in),
		.out_valid(v_d1), .quotient(q1), .sb_out(sb1_out)
	);

	// stage 3: B5, B6
	logic v_s3, f_s3;
	logic [DATA_W-1:0] b5_s3, b6_s3;
	logic [UP_W-1:0] up_s3;
	// stage 4: (B6*B6)>>12, AC2*B6, AC3*B6
	logic v_s4, f_s4;
	logic [DATA_W-1:0] b5_s4, sq_s4, pa2_s4, pa3_s4;
	logic [UP_W-1:0] up_s4;
	// stage 5: B2*sq, B1*sq
	logic v_s5, f_s5;
	logic [DATA_W-1:0] b5_s5, mb2_s5, mb1_s5, pa2_s5, pa3_s5;
	logic [UP_W-1:0] up_s5;
	// stage 6: B3 and the B4 operand
	logic v_s6, f_s6;
	logic [DATA_W-1:0] b5_s6, b3_s6, x3_s6;
	logic [UP_W-1:0] up_s6;
	// stage 7: B4, UP - B3
	logic v_s7, f_s7;
	logic [DATA_W-1:0] b5_s7, b4_s7, dup_s7;
	// stage 8: B7
	logic v_s8, f_s8;
	logic [DATA_W-1:0] b5_s8, b4_s8, b7_s8;

	logic [DATA_W-1:0] q1_sgn, b5_c, x3a_c, b3t_c, x3b_c;
	always_comb begin
		q1_sgn = sb1_out[SB1_W-1] ? -q1 : q1;
		b5_c = sb1_out[UP_W +: DATA_W] + q1_sgn;
		x3a_c = asr(mb2_s5, 11) + asr(pa2_s5, 11);
		b3t_c = ((ac1 << 2) + x3a_c) << oss_q;
		x3b_c = asr(asr(pa3_s5, 13) + asr(mb1_s5, 16) + 32'd2, 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_d1;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s3 <= sb1_out[SB1_W-2];
			b5_s3 <= b5_c;
			b6_s3 <= b5_c - C_B6_OFS;
			up_s3 <= sb1_out[UP_W-1:0];

			f_s4 <= f_s3;
			b5_s4 <= b5_s3;
			sq_s4 <= asr(mul_lo(b6_s3, b6_s3), 12);
			pa2_s4 <= mul_lo(ac2, b6_s3);
			pa3_s4 <= mul_lo(ac3, b6_s3);
			up_s4 <= up_s3;

			f_s5 <= f_s4;
			b5_s5 <= b5_s4;
			mb2_s5 <= mul_lo(b2, sq_s4);
			mb1_s5 <= mul_lo(b1, sq_s4);
			pa2_s5 <= pa2_s4;
			pa3_s5 <= pa3_s4;
			up_s5 <= up_s4;

			f_s6 <= f_s5;
			b5_s6 <= b5_s5;
			b3_s6 <= asr(b3t_c + 32'd2, 2);
			x3_s6 <= x3b_c;
			up_s6 <= up_s5;

			f_s7 <= f_s6;
			b5_s7 <= b5_s6;
			b4_s7 <= mul_lo(ac4, x3_s6 + C_HALF) >> 15;
			dup_s7 <= {8'b0, up_s6} - b3_s6;

			f_s8 <= f_s7;
			b5_s8 <= b5_s7;
			b4_s8 <= b4_s7;
			b7_s8 <= mul_lo(dup_s7, C_B7_SCALE >> oss_q);
		end
	end

	// pressure quotient: double before dividing unless B7 has its top bit set
	logic big2, fault2;
	logic [DATA_W-1:0] num2, q2;
	logic [SB2_W-1:0] sb2_in, sb2_out;
	logic v_d2;

	always_comb begin
		big2 = b7_s8[DATA_W-1];
		num2 = big2 ? b7_s8 : (b7_s8 << 1);
		fault2 = f_s8 || (b4_s8 == '0);
		sb2_in = {fault2, big2, b5_s8};
	end

	bpc_div_chain #(.W(DATA_W), .SB_W(SB2_W)) u_div_p (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(v_s8),
		.dividend(num2), .divisor(b4_s8), .sb_in(sb2_in),
		.out_valid(v_d2), .quotient(q2), .sb_out(sb2_out)
	);

	// stage 9: p; stage 10: (p>>8)^2 and -7357*p; stage 11: *3038
	logic v_s9, v_s10, v_s11;
	logic f_s9, f_s10, f_s11;
	logic [DATA_W-1:0] b5_s9, b5_s10, b5_s11;
	logic [DATA_W-1:0] p_s9, p_s10, p_s11, pp_s10, m7_s10, m7_s11, x1m_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_d2;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			out_valid_q <= v_s11;
		end
	end

	logic signed [DATA_W-1:0] t_c, pf_c;
	logic [15:0] t_sat;
	logic [19:0] p_sat;

	always_comb begin
		t_c = $signed(asr(b5_s11 + 32'd8, 4));
		if (t_c > C_TEMP_MAX) begin
			t_sat = 16'h7FFF;
		end else if (t_c < C_TEMP_MIN) begin
			t_sat = 16'h8000;
		end else begin
			t_sat = t_c[15:0];
		end
		pf_c = $signed(p_s11 + asr(asr(x1m_s11, 16) + asr(m7_s11, 16) + C_P_K3, 4));
		if (pf_c < 0) begin
			p_sat = '0;
		end else if (pf_c > C_PRESS_MAX) begin
			p_sat = 20'hFFFFF;
		end else begin
			p_sat = pf_c[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s9 <= sb2_out[SB2_W-1];
			b5_s9 <= sb2_out[DATA_W-1:0];
			p_s9 <= sb2_out[SB2_W-2] ? (q2 << 1) : q2;

			f_s10 <= f_s9;
			b5_s10 <= b5_s9;
			p_s10 <= p_s9;
			pp_s10 <= mul_lo(asr(p_s9, 8), asr(p_s9, 8));
			m7_s10 <= mul_lo(C_P_K2, p_s9);

			f_s11 <= f_s10;
			b5_s11 <= b5_s10;
			p_s11 <= p_s10;
			m7_s11 <= m7_s10;
			x1m_s11 <= mul_lo(pp_s10, C_P_K1);

			// a zero divisor anywhere forces both values to zero
			div_fault <= f_s11;
			temp_tenths <= f_s11 ? '0 : t_sat;
			press_pa <= f_s11 ? '0 : p_sat;
		end
	end

	assign out_valid = out_valid_q;

	// a faulted item carries zero values
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_fault |-> temp_tenths == '0 && press_pa == '0)
		else $error("fault item with nonzero values");

	// input is refused only while a result waits
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// a stalled pipeline keeps its last stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s11) && $stable(p_s11))
		else $error("pipeline moved while stalled");

endmodule
